// File: sv/ddodo_pkg.sv
// ddodo_pkg: shared types, constants and the cordic arctangent table
// for the differential drive odometry block; no dependencies
package ddodo_pkg;

  // configuration register indexes
  localparam logic [7:0] REG_LEFT_SCALE  = 8'd0;
  localparam logic [7:0] REG_RIGHT_SCALE = 8'd1;
  localparam logic [7:0] REG_TURN_GAIN   = 8'd2;
  localparam logic [7:0] REG_DRIFT_GAIN  = 8'd3;

  // fixed-point constants
  localparam logic [47:0] ARC_C_Q30      = 48'd1766234505;  // pi^2/6
  localparam logic [47:0] TWO_PI_Q28     = 48'd1686629713;
  localparam logic [33:0] CORDIC_INV_Q30 = 34'd652032874;
  localparam logic [31:0] ONE_Q30        = 32'h4000_0000;

  // multiplications issued by the controller, in sequence order
  typedef enum logic [3:0] {
    OP_WL, OP_WR, OP_GHI, OP_GLO, OP_TSQ, OP_K, OP_KD,
    OP_DX, OP_DY, OP_DQ, OP_DRF, OP_MX, OP_MY
  } mul_op_e;

  typedef struct packed {
    logic       mul_start;
    logic       mul_store;
    mul_op_e    op;
    logic       cor_init;
    logic       cor_step;
    logic [4:0] cor_idx;
    logic       cor_store;
    logic       final_write;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
  } dp_status_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;
      5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: sv/ddodo_ctrl.sv
// ddodo_ctrl: sequencer for the odometry datapath and the output valid
// depends on ddodo_pkg
module ddodo_ctrl import ddodo_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_op_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam int CW = $clog2(CORDIC_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_MSTART, S_MWAIT, S_MSTORE, S_CINIT, S_CSTEP, S_CSTORE,
    S_FINAL, S_WRITE
  } state_e;

  state_e        state_q;
  dp_cmd_t       cmd_q;
  logic [CW-1:0] cnt_q;
  logic          valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cmd_q.mul_start   <= 1'b0;
      cmd_q.mul_store   <= 1'b0;
      cmd_q.cor_init    <= 1'b0;
      cmd_q.cor_step    <= 1'b0;
      cmd_q.cor_store   <= 1'b0;
      cmd_q.final_write <= 1'b0;
      if (valid_q && out_ready_i) begin
        valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_op_i) begin
              state_q <= S_FINAL;
            end else begin
              cmd_q.op        <= OP_WL;
              cmd_q.mul_start <= 1'b1;
              state_q         <= S_MSTART;
            end
          end
        end
        S_MSTART: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (!status_i.mul_busy) begin
            cmd_q.mul_store <= 1'b1;
            state_q         <= S_MSTORE;
          end
        end
        S_MSTORE: begin
          if (cmd_q.op == OP_KD) begin
            cmd_q.cor_init <= 1'b1;
            state_q        <= S_CINIT;
          end else if (cmd_q.op == OP_MY) begin
            state_q <= S_FINAL;
          end else begin
            cmd_q.op        <= mul_op_e'(cmd_q.op + 4'd1);
            cmd_q.mul_start <= 1'b1;
            state_q         <= S_MSTART;
          end
        end
        S_CINIT: begin
          cnt_q          <= '0;
          cmd_q.cor_step <= 1'b1;
          cmd_q.cor_idx  <= '0;
          state_q        <= S_CSTEP;
        end
        S_CSTEP: begin
          if (cnt_q == CW'(CORDIC_STEPS - 1)) begin
            cmd_q.cor_store <= 1'b1;
            state_q         <= S_CSTORE;
          end else begin
            cnt_q          <= cnt_q + 1'b1;
            cmd_q.cor_step <= 1'b1;
            cmd_q.cor_idx  <= 5'(cnt_q + 1'b1);
          end
        end
        S_CSTORE: begin
          cmd_q.op        <= OP_DX;
          cmd_q.mul_start <= 1'b1;
          state_q         <= S_MSTART;
        end
        S_FINAL: begin
          // output register free now or emptied at this edge
          if (!valid_q || out_ready_i) begin
            cmd_q.final_write <= 1'b1;
            state_q           <= S_WRITE;
          end
        end
        S_WRITE: begin
          valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/ddodo_datapath.sv
// ddodo_datapath: configuration, pose state, digit-serial multiplier,
// cordic rotator and output registers; depends on ddodo_pkg
module ddodo_datapath import ddodo_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        ld_i,
  input  logic        ld_op_i,
  input  logic [191:0] ld_data_i,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  output logic [199:0] out_data_o
);

  // configuration
  logic [31:0] ls_q, rs_q, tg_q, dg_q;
  // latched item
  logic        op_q;
  logic [31:0] lc_q, rc_q, ph_q;
  logic [47:0] px_q, py_q;
  // pose state
  logic [31:0] last_l_q, last_r_q, hd_q;
  logic [47:0] pos_x_q, pos_y_q;
  // intermediates
  logic [55:0] wl_q;
  logic [47:0] diff_q;
  logic [39:0] dist_q;
  logic [40:0] t1_q;
  logic [31:0] turn_q, tsq_q, k_q, dq_q;
  logic [41:0] kd_q, dx_q, dy_q;
  logic [33:0] c_q, s_q;
  logic [39:0] drf_q;
  logic [49:0] mx_q, my_q;
  // cordic
  logic [33:0] cx_q, cy_q, cz_q;
  logic        neg_q;
  // multiplier
  logic [49:0] ma_q, ma_d;
  logic [47:0] mb_q, mb_d;
  logic [97:0] acc_q;
  logic [1:0]  mcnt_q;
  logic        mbusy_q;
  // outputs
  logic [47:0] ox_q, oy_q;
  logic [31:0] oh_q, ot_q;
  logic [39:0] od_q;

  logic [31:0] dl, dr;
  logic [16:0] dgt;
  logic signed [66:0] pp;
  logic [97:0] ppx, ppsh;

  assign dl = lc_q - last_l_q;
  assign dr = rc_q - last_r_q;
  assign status_o.mul_busy = mbusy_q;
  assign out_data_o = {ot_q, od_q, oh_q, oy_q, ox_q};

  // operand selection
  always_comb begin
    ma_d = '0;
    mb_d = '0;
    case (cmd_i.op)
      OP_WL:  begin ma_d = {{18{dl[31]}}, dl}; mb_d = {16'd0, ls_q}; end
      OP_WR:  begin ma_d = {{18{dr[31]}}, dr}; mb_d = {16'd0, rs_q}; end
      OP_GHI: begin ma_d = {{2{diff_q[47]}}, diff_q}; mb_d = {32'd0, tg_q[31:16]}; end
      OP_GLO: begin ma_d = {{2{diff_q[47]}}, diff_q}; mb_d = {32'd0, tg_q[15:0]}; end
      OP_TSQ: begin
        ma_d = {{18{turn_q[31]}}, turn_q};
        mb_d = {{16{turn_q[31]}}, turn_q};
      end
      OP_K:   begin ma_d = {18'd0, tsq_q}; mb_d = ARC_C_Q30; end
      OP_KD:  begin ma_d = {{10{dist_q[39]}}, dist_q}; mb_d = {{16{k_q[31]}}, k_q}; end
      OP_DX:  begin ma_d = {{8{kd_q[41]}}, kd_q}; mb_d = {{14{c_q[33]}}, c_q}; end
      OP_DY:  begin ma_d = {{8{kd_q[41]}}, kd_q}; mb_d = {{14{s_q[33]}}, s_q}; end
      OP_DQ:  begin ma_d = {{18{turn_q[31]}}, turn_q}; mb_d = TWO_PI_Q28; end
      OP_DRF: begin ma_d = {{18{dg_q[31]}}, dg_q}; mb_d = {{16{dq_q[31]}}, dq_q}; end
      OP_MX:  begin ma_d = {{8{dy_q[41]}}, dy_q}; mb_d = {{8{drf_q[39]}}, drf_q}; end
      OP_MY:  begin ma_d = {{8{dx_q[41]}}, dx_q}; mb_d = {{8{drf_q[39]}}, drf_q}; end
      default: begin ma_d = '0; mb_d = '0; end
    endcase
  end

  // one 16-bit digit of b per cycle, top digit signed
  always_comb begin
    case (mcnt_q)
      2'd0:    dgt = {1'b0, mb_q[15:0]};
      2'd1:    dgt = {1'b0, mb_q[31:16]};
      default: dgt = {mb_q[47], mb_q[47:32]};
    endcase
    pp  = $signed(ma_q) * $signed(dgt);
    ppx = {{31{pp[66]}}, pp};
    case (mcnt_q)
      2'd0:    ppsh = ppx;
      2'd1:    ppsh = {ppx[81:0], 16'd0};
      default: ppsh = {ppx[65:0], 32'd0};
    endcase
  end

  // product post-processing
  logic [55:0] wr;
  logic [56:0] wsum, wdif;
  logic [39:0] dist_d;
  logic [47:0] diff_d;
  logic [40:0] t1_d;
  logic [48:0] tsum;
  logic [31:0] turn_d;

  always_comb begin
    wr   = acc_q[63:8];
    wsum = {wl_q[55], wl_q} + {wr[55], wr};
    wdif = {wr[55], wr} - {wl_q[55], wl_q};
    if ((&wsum[56:40]) || !(|wsum[56:40])) begin
      dist_d = wsum[40:1];
    end else begin
      dist_d = wsum[56] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end
    if ((&wdif[56:47]) || !(|wdif[56:47])) begin
      diff_d = wdif[47:0];
    end else begin
      diff_d = wdif[56] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    if ((&acc_q[97:40]) || !(|acc_q[97:40])) begin
      t1_d = acc_q[40:0];
    end else begin
      t1_d = acc_q[97] ? {1'b1, 40'd0} : {1'b0, {40{1'b1}}};
    end
    tsum = {{8{t1_q[40]}}, t1_q} + {acc_q[63], acc_q[63:16]};
    if ((&tsum[48:31]) || !(|tsum[48:31])) begin
      turn_d = tsum[31:0];
    end else begin
      turn_d = tsum[48] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end
  end

  // cordic
  logic [31:0] ang;
  logic signed [33:0] xsh, ysh;
  logic [33:0] at;

  assign ang = hd_q + {turn_q[31], turn_q[31:1]};
  assign xsh = $signed(cx_q) >>> cmd_i.cor_idx;
  assign ysh = $signed(cy_q) >>> cmd_i.cor_idx;
  assign at  = {2'b00, atan_lut(cmd_i.cor_idx)};

  // final pose
  logic [51:0] nx, ny;
  logic [47:0] nx_sat, ny_sat;

  always_comb begin
    nx = {{4{pos_x_q[47]}}, pos_x_q} + {{10{dx_q[41]}}, dx_q} + {{2{mx_q[49]}}, mx_q};
    ny = {{4{pos_y_q[47]}}, pos_y_q} + {{10{dy_q[41]}}, dy_q} - {{2{my_q[49]}}, my_q};
    if ((&nx[51:47]) || !(|nx[51:47])) begin
      nx_sat = nx[47:0];
    end else begin
      nx_sat = nx[51] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    if ((&ny[51:47]) || !(|ny[51:47])) begin
      ny_sat = ny[47:0];
    end else begin
      ny_sat = ny[51] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q     <= '0;
      rs_q     <= '0;
      tg_q     <= '0;
      dg_q     <= '0;
      last_l_q <= '0;
      last_r_q <= '0;
      hd_q     <= '0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      mcnt_q   <= '0;
      mbusy_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LEFT_SCALE:  ls_q <= cfg_data_i;
          REG_RIGHT_SCALE: rs_q <= cfg_data_i;
          REG_TURN_GAIN:   tg_q <= cfg_data_i;
          REG_DRIFT_GAIN:  dg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.mul_start) begin
        mbusy_q <= 1'b1;
        mcnt_q  <= '0;
      end else if (mbusy_q) begin
        if (mcnt_q == 2'd2) begin
          mbusy_q <= 1'b0;
        end else begin
          mcnt_q <= mcnt_q + 2'd1;
        end
      end
      if (cmd_i.final_write) begin
        if (op_q) begin
          pos_x_q <= px_q;
          pos_y_q <= py_q;
          hd_q    <= ph_q;
        end else begin
          pos_x_q  <= nx_sat;
          pos_y_q  <= ny_sat;
          hd_q     <= hd_q + turn_q;
          last_l_q <= lc_q;
          last_r_q <= rc_q;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      op_q <= ld_op_i;
      lc_q <= ld_data_i[31:0];
      rc_q <= ld_data_i[63:32];
      px_q <= ld_data_i[111:64];
      py_q <= ld_data_i[159:112];
      ph_q <= ld_data_i[191:160];
    end
    if (cmd_i.mul_start) begin
      ma_q  <= ma_d;
      mb_q  <= mb_d;
      acc_q <= '0;
    end else if (mbusy_q) begin
      acc_q <= acc_q + ppsh;
    end
    if (cmd_i.mul_store) begin
      case (cmd_i.op)
        OP_WL:  wl_q <= acc_q[63:8];
        OP_WR:  begin dist_q <= dist_d; diff_q <= diff_d; end
        OP_GHI: t1_q <= t1_d;
        OP_GLO: turn_q <= turn_d;
        OP_TSQ: tsq_q <= acc_q[63:32];
        OP_K:   k_q <= ONE_Q30 - acc_q[63:32];
        OP_KD:  kd_q <= acc_q[71:30];
        OP_DX:  dx_q <= acc_q[71:30];
        OP_DY:  dy_q <= acc_q[71:30];
        OP_DQ:  dq_q <= acc_q[63:32];
        OP_DRF: drf_q <= acc_q[61:22];
        OP_MX:  mx_q <= acc_q[79:30];
        OP_MY:  my_q <= acc_q[79:30];
        default: ;
      endcase
    end
    if (cmd_i.cor_init) begin
      // fold the half turn around the x axis and negate the result later
      neg_q <= ang[31] ^ ang[30];
      cx_q  <= CORDIC_INV_Q30;
      cy_q  <= '0;
      cz_q  <= {{2{ang[30]}}, ang[30], ang[30:0]};
    end else if (cmd_i.cor_step) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - ysh;
        cy_q <= cy_q + xsh;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ysh;
        cy_q <= cy_q - xsh;
        cz_q <= cz_q + at;
      end
    end
    if (cmd_i.cor_store) begin
      c_q <= neg_q ? (34'd0 - cx_q) : cx_q;
      s_q <= neg_q ? (34'd0 - cy_q) : cy_q;
    end
    if (cmd_i.final_write) begin
      if (op_q) begin
        ox_q <= px_q;
        oy_q <= py_q;
        oh_q <= ph_q;
        od_q <= '0;
        ot_q <= '0;
      end else begin
        ox_q <= nx_sat;
        oy_q <= ny_sat;
        oh_q <= hd_q + turn_q;
        od_q <= dist_q;
        ot_q <= turn_q;
      end
    end
  end

endmodule

// File: sv/differential_drive_odometry.sv
// differential_drive_odometry: top level of the wheel odometry block
// depends on ddodo_pkg, ddodo_ctrl and ddodo_datapath
//
// Usage: each input transaction on the s_axis channel is either an encoder
// update (tuser 0, cumulative left/right counts) or a set-pose command
// (tuser 1, new x, y and heading). Every input transaction yields exactly
// one m_axis transaction carrying the pose after the item together with
// the travel and turn of that update (both zero for a set pose).
// Registers (wheel scales, turn gain, drift gain) are written over the
// cfg channel, which is always ready; write them only while idle.
// Processing: a set pose goes straight to the final write; an encoder
// update runs thirteen products on one 50x17 digit-serial multiplier
// and CORDIC_STEPS cordic rotation steps, one step per cycle.
// One item is processed at a time; the next one is taken as soon as the
// previous result sits in the output register, even if not yet taken.
// When the receiver stalls, a finished item waits until the output
// register frees. Reset clears the pose, stored counts and registers.
module differential_drive_odometry import ddodo_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // left_count, right_count, pose_x, pose_y, pose_heading
  input  logic [191:0] s_axis_tdata,
  // op
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // x, y, heading, step_distance, step_turn
  output logic [199:0] m_axis_tdata
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       ld;

  assign cfg_ready_o = 1'b1;
  assign ld = s_axis_tvalid & s_axis_tready;

  ddodo_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ddodo_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .ld_i       (ld),
    .ld_op_i    (s_axis_tuser),
    .ld_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (m_axis_tdata)
  );

endmodule
